// ----- src/ape_pkg.sv -----
// Shared types, field widths and constants of the Alamouti pair equalizer.
// Used by ape_products, ape_combine, ape_round and the top level; depends on nothing else.

package ape_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PAIR_W     = 7;
    localparam int MARKER_W   = 2;
    localparam int PROD_W     = 2 * SAMPLE_W;
    // Four exact Q2.30 products summed need two more bits.
    localparam int LANE_W     = PROD_W + 2;
    // Common Q.30 domain ahead of rounding: lane << 14 or lane * 23170.
    localparam int SCALED_W   = LANE_W + 15;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;

    localparam logic [MARKER_W-1:0] MARKER_NORMAL = 2'd0;
    localparam logic [MARKER_W-1:0] MARKER_HALVE  = 2'd1;

    // 1/sqrt(2) in Q1.15.
    localparam logic signed [SAMPLE_W-1:0] INV_SQRT2_Q15 = 16'sd23170;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [LANE_W-1:0]   t_lane;
    typedef logic signed [SCALED_W-1:0] t_scaled;

    typedef struct packed {
        t_sample re;
        t_sample im;
    } t_cplx;

    // Partial products of one complex multiply x*h.
    typedef struct packed {
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri;
        logic signed [PROD_W-1:0] ir;
    } t_cprod;

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic              in_range;
        logic              halve;
        logic              pilot;
    } t_ctrl;

    // Pilot pairs are those whose even carrier is 24, 44, 64, 84, 124, 144, 164 or 184.
    function automatic logic is_pilot_pair(input logic [PAIR_W-1:0] p);
        return p inside {7'd12, 7'd22, 7'd32, 7'd42, 7'd62, 7'd72, 7'd82, 7'd92};
    endfunction

endpackage

// ----- src/ape_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; holds the per-pair channel estimates of the equalizer.

module ape_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ape_products.sv -----
// Second pipeline stage: picks the live or stored estimates and forms the
// sixteen partial products of x0*h0, x1*h0, x0*h1 and x1*h1. Uses ape_pkg.

module ape_products (
    input  logic           i_clk,
    input  logic           i_en,
    input  ape_pkg::t_ctrl i_ctrl,
    input  logic           i_load,
    input  ape_pkg::t_cplx i_x0,
    input  ape_pkg::t_cplx i_x1,
    input  ape_pkg::t_cplx i_h0_in,
    input  ape_pkg::t_cplx i_h1_in,
    input  ape_pkg::t_cplx i_h0_mem,
    input  ape_pkg::t_cplx i_h1_mem,
    output ape_pkg::t_ctrl o_ctrl,
    output ape_pkg::t_cplx o_x0,
    output ape_pkg::t_cplx o_x1,
    output ape_pkg::t_cprod o_a,
    output ape_pkg::t_cprod o_b,
    output ape_pkg::t_cprod o_c,
    output ape_pkg::t_cprod o_d
);

    import ape_pkg::*;

    function automatic t_cprod cmul_terms(input t_cplx x, input t_cplx h);
        t_cprod p;
        p.rr = x.re * h.re;
        p.ii = x.im * h.im;
        p.ri = x.re * h.im;
        p.ir = x.im * h.re;
        return p;
    endfunction

    t_cplx  h0;
    t_cplx  h1;
    t_ctrl  r_ctrl;
    t_cplx  r_x0;
    t_cplx  r_x1;
    t_cprod r_a;
    t_cprod r_b;
    t_cprod r_c;
    t_cprod r_d;

    // A loading transaction uses the estimates it carries; the registered store
    // read data still holds the old ones on this cycle.
    assign h0 = i_load ? i_h0_in : i_h0_mem;
    assign h1 = i_load ? i_h1_in : i_h1_mem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= i_ctrl;
            r_x0   <= i_x0;
            r_x1   <= i_x1;
            r_a    <= cmul_terms(i_x0, h0);
            r_b    <= cmul_terms(i_x1, h0);
            r_c    <= cmul_terms(i_x0, h1);
            r_d    <= cmul_terms(i_x1, h1);
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_x0   = r_x0;
    assign o_x1   = r_x1;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_c    = r_c;
    assign o_d    = r_d;

endmodule

// ----- src/ape_combine.sv -----
// Third pipeline stage: sums the partial products into the four output lanes
// for normal and pilot pairs; halved frame-start pairs are shifted. Uses ape_pkg.

module ape_combine (
    input  logic            i_clk,
    input  logic            i_en,
    input  ape_pkg::t_ctrl  i_ctrl,
    input  ape_pkg::t_cplx  i_x0,
    input  ape_pkg::t_cplx  i_x1,
    input  ape_pkg::t_cprod i_a,
    input  ape_pkg::t_cprod i_b,
    input  ape_pkg::t_cprod i_c,
    input  ape_pkg::t_cprod i_d,
    output ape_pkg::t_ctrl  o_ctrl,
    output ape_pkg::t_lane  o_lane [4]
);

    import ape_pkg::*;

    t_lane n_lane [4];
    t_lane r_lane [4];
    t_ctrl r_ctrl;

    // Lanes are in Q.30 with a later shift of 16: halved samples enter as x << 15.
    always_comb begin
        if (!i_ctrl.in_range) begin
            for (int i = 0; i < 4; i++) begin
                n_lane[i] = '0;
            end
        end else if (i_ctrl.halve) begin
            n_lane[0] = t_lane'(i_x0.re) <<< 15;
            n_lane[1] = t_lane'(i_x0.im) <<< 15;
            n_lane[2] = t_lane'(i_x1.re) <<< 15;
            n_lane[3] = t_lane'(i_x1.im) <<< 15;
        end else if (i_ctrl.pilot) begin
            n_lane[0] = t_lane'(i_a.rr) - t_lane'(i_a.ii);
            n_lane[1] = t_lane'(i_a.ri) + t_lane'(i_a.ir);
            n_lane[2] = t_lane'(i_b.ii) - t_lane'(i_b.rr);
            n_lane[3] = t_lane'(i_b.ri) + t_lane'(i_b.ir);
        end else begin
            n_lane[0] = t_lane'(i_a.rr) - t_lane'(i_a.ii)
                      + t_lane'(i_d.rr) - t_lane'(i_d.ii);
            n_lane[1] = t_lane'(i_a.ri) + t_lane'(i_a.ir)
                      - t_lane'(i_d.ri) - t_lane'(i_d.ir);
            n_lane[2] = t_lane'(i_c.rr) - t_lane'(i_c.ii)
                      - t_lane'(i_b.rr) + t_lane'(i_b.ii);
            n_lane[3] = t_lane'(i_c.ri) + t_lane'(i_c.ir)
                      + t_lane'(i_b.ri) + t_lane'(i_b.ir);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= i_ctrl;
            r_lane <= n_lane;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_lane = r_lane;

endmodule

// ----- src/ape_round.sv -----
// Fourth and fifth pipeline stages: brings every lane into one Q.30 domain
// (the odd pilot lanes through the 1/sqrt2 multiply), then rounds half up and
// saturates to Q1.15 into the output register. Uses ape_pkg.

module ape_round (
    input  logic                          i_clk,
    input  logic                          i_en_scale,
    input  logic                          i_en_out,
    input  ape_pkg::t_ctrl                i_ctrl,
    input  ape_pkg::t_lane                i_lane [4],
    output logic [ape_pkg::PAIR_W-1:0]    o_pair,
    output ape_pkg::t_sample              o_sample [4]
);

    import ape_pkg::*;

    function automatic t_sample round_sat(input t_scaled w);
        t_scaled t;
        t_scaled q;
        t = w + (t_scaled'(1) <<< 29);
        q = t >>> 30;
        if (q > t_scaled'(32767)) begin
            return 16'sh7fff;
        end else if (q < -t_scaled'(32768)) begin
            return 16'sh8000;
        end else begin
            return q[SAMPLE_W-1:0];
        end
    endfunction

    logic             scale_odd;
    t_scaled          n_w [4];
    t_scaled          r_w [4];
    logic [PAIR_W-1:0] r_pair4;
    logic [PAIR_W-1:0] r_pair;
    t_sample          r_out [4];

    assign scale_odd = i_ctrl.pilot && !i_ctrl.halve;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i >= 2 && scale_odd) begin
                n_w[i] = t_scaled'(i_lane[i]) * t_scaled'(INV_SQRT2_Q15);
            end else begin
                n_w[i] = t_scaled'(i_lane[i]) <<< 14;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_scale) begin
            r_pair4 <= i_ctrl.pair;
            r_w     <= n_w;
        end
        if (i_en_out) begin
            r_pair <= r_pair4;
            for (int i = 0; i < 4; i++) begin
                r_out[i] <= round_sat(r_w[i]);
            end
        end
    end

    assign o_pair   = r_pair;
    assign o_sample = r_out;

endmodule

// ----- src/alamouti_pair_equalizer_unit.sv -----
// Top level of the Alamouti pair equalizer: stream ports, estimate stores,
// pipeline flow control. Uses ape_pkg, ape_ram, ape_products, ape_combine, ape_round.

// The equalizer takes one subcarrier pair per clock while s_axis_tready is high
// and returns one result per pair, in order. The five register stages are the
// estimate store read, the partial-product multipliers, the combining adders,
// the Q.30 scaling with the 1/sqrt2 multiplier, and the round and saturate
// into the output register. Every stage has its own valid bit and only stalls
// when the stage behind it is full, so bubbles close up and input is taken
// while a finished result waits. Estimates are written into the stores on
// the input transaction of a pair with a nonzero frame marker; a pair with
// marker zero must follow a load of the same pair. Pairs at or above VLEN/2
// store nothing and return zero samples.

module alamouti_pair_equalizer_unit #(
    parameter int VLEN = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pair_index, even_sample_re, even_sample_im, odd_sample_re, odd_sample_im,
    // chan0_re, chan0_im, chan1_re, chan1_im, one zero pad bit
    input  logic [ape_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // frame_marker
    input  logic [ape_pkg::MARKER_W-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pair_number, even_out_re, even_out_im, odd_out_re, odd_out_im, one zero pad bit
    output logic [ape_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import ape_pkg::*;

    localparam int NPAIRS = (VLEN / 2 < 128) ? VLEN / 2 : 128;
    localparam int ADDR_W = $clog2(NPAIRS);

    logic [PAIR_W-1:0] in_pair;
    t_cplx             in_x0;
    t_cplx             in_x1;
    t_cplx             in_h0;
    t_cplx             in_h1;
    logic              in_load;
    t_ctrl             in_ctrl;
    logic              store_we;

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic r_v5;

    t_ctrl r_s1_ctrl;
    logic  r_s1_load;
    t_cplx r_s1_x0;
    t_cplx r_s1_x1;
    t_cplx r_s1_h0;
    t_cplx r_s1_h1;
    t_cplx mem_h0;
    t_cplx mem_h1;

    t_ctrl  s2_ctrl;
    t_cplx  s2_x0;
    t_cplx  s2_x1;
    t_cprod s2_a;
    t_cprod s2_b;
    t_cprod s2_c;
    t_cprod s2_d;

    t_ctrl  s3_ctrl;
    t_lane  s3_lane [4];

    logic [PAIR_W-1:0] out_pair;
    t_sample           out_sample [4];

    assign in_pair  = s_axis_tdata[6:0];
    assign in_x0.re = s_axis_tdata[22:7];
    assign in_x0.im = s_axis_tdata[38:23];
    assign in_x1.re = s_axis_tdata[54:39];
    assign in_x1.im = s_axis_tdata[70:55];
    assign in_h0.re = s_axis_tdata[86:71];
    assign in_h0.im = s_axis_tdata[102:87];
    assign in_h1.re = s_axis_tdata[118:103];
    assign in_h1.im = s_axis_tdata[134:119];
    assign in_load  = (s_axis_tuser != MARKER_NORMAL);

    assign in_ctrl.pair     = in_pair;
    assign in_ctrl.in_range = (int'(in_pair) < VLEN / 2);
    assign in_ctrl.halve    = (s_axis_tuser == MARKER_HALVE);
    assign in_ctrl.pilot    = is_pilot_pair(in_pair);

    // A stage takes new data when it is empty or the stage behind it moves.
    assign en5 = !r_v5 || m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;
    assign store_we      = s_axis_tvalid && en1 && in_load && in_ctrl.in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_ctrl <= in_ctrl;
            r_s1_load <= in_load;
            r_s1_x0   <= in_x0;
            r_s1_x1   <= in_x1;
            r_s1_h0   <= in_h0;
            r_s1_h1   <= in_h1;
        end
    end

    // The store read is issued with the input transaction, so its registered
    // data lines up with stage one and holds while stage one is stalled.
    ape_ram #(
        .WIDTH ($bits(t_cplx)),
        .DEPTH (NPAIRS)
    ) u_chan0_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (in_pair[ADDR_W-1:0]),
        .i_wdata (in_h0),
        .i_re    (en1),
        .i_raddr (in_pair[ADDR_W-1:0]),
        .o_rdata (mem_h0)
    );

    ape_ram #(
        .WIDTH ($bits(t_cplx)),
        .DEPTH (NPAIRS)
    ) u_chan1_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (in_pair[ADDR_W-1:0]),
        .i_wdata (in_h1),
        .i_re    (en1),
        .i_raddr (in_pair[ADDR_W-1:0]),
        .o_rdata (mem_h1)
    );

    ape_products u_products (
        .i_clk    (i_clk),
        .i_en     (en2),
        .i_ctrl   (r_s1_ctrl),
        .i_load   (r_s1_load),
        .i_x0     (r_s1_x0),
        .i_x1     (r_s1_x1),
        .i_h0_in  (r_s1_h0),
        .i_h1_in  (r_s1_h1),
        .i_h0_mem (mem_h0),
        .i_h1_mem (mem_h1),
        .o_ctrl   (s2_ctrl),
        .o_x0     (s2_x0),
        .o_x1     (s2_x1),
        .o_a      (s2_a),
        .o_b      (s2_b),
        .o_c      (s2_c),
        .o_d      (s2_d)
    );

    ape_combine u_combine (
        .i_clk  (i_clk),
        .i_en   (en3),
        .i_ctrl (s2_ctrl),
        .i_x0   (s2_x0),
        .i_x1   (s2_x1),
        .i_a    (s2_a),
        .i_b    (s2_b),
        .i_c    (s2_c),
        .i_d    (s2_d),
        .o_ctrl (s3_ctrl),
        .o_lane (s3_lane)
    );

    ape_round u_round (
        .i_clk      (i_clk),
        .i_en_scale (en4),
        .i_en_out   (en5),
        .i_ctrl     (s3_ctrl),
        .i_lane     (s3_lane),
        .o_pair     (out_pair),
        .o_sample   (out_sample)
    );

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {1'b0, out_sample[3], out_sample[2], out_sample[1],
                            out_sample[0], out_pair};

endmodule

// ----- src/ape_checker.sv -----
// Port-level checks of the Alamouti pair equalizer and the bind that attaches
// them to the top level. Sees only the top-level ports.

module ape_checker #(
    parameter int VLEN = 256
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [135:0] s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or was dropped");

    // A waiting input transaction stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready
        |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("waiting input changed or was withdrawn");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // With no result waiting, no stage can be blocked, so input is taken.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled although the output register is empty");

    // Pairs beyond the symbol carry zero samples.
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (int'(m_axis_tdata[6:0]) >= VLEN / 2)
        |-> (m_axis_tdata[70:7] == '0))
        else $error("pair beyond the symbol returned nonzero samples");

endmodule

bind alamouti_pair_equalizer_unit ape_checker #(.VLEN(VLEN)) u_ape_checker (.*);
